@@ src/isfd_pkg.sv @@
// ----------------------------------------------------------------------------
// isfd_pkg
// Shared types and constants of the IMU serial frame decoder: frame layout,
// type codes, result kinds and the fixed-point scaling constants.
// ----------------------------------------------------------------------------
package isfd_pkg;

    // frame layout
    localparam int ISFD_POS_W      = 4;
    localparam int ISFD_LAST_POS   = 10;   // position of the checksum byte
    localparam int ISFD_STORE_LO   = 1;    // first stored byte (type)
    localparam int ISFD_STORE_HI   = 9;    // last stored byte (high byte of word 3)
    localparam int ISFD_NUM_WORDS  = 4;
    localparam int ISFD_NUM_AXES   = 3;

    // configuration port
    localparam int          ISFD_ADDR_W       = 3;
    localparam int          ISFD_DATA_W       = 32;
    localparam logic        ISFD_REG_HEADER   = 1'b0;   // paddr[2] of header_value
    localparam logic [7:0]  ISFD_HEADER_RESET = 8'h55;

    // frame type codes
    localparam logic [7:0] ISFD_TYPE_ACCEL = 8'h51;
    localparam logic [7:0] ISFD_TYPE_RATE  = 8'h52;
    localparam logic [7:0] ISFD_TYPE_ANGLE = 8'h53;

    // widths of the data path
    localparam int ISFD_AXIS_W = 20;
    localparam int ISFD_TEMP_W = 10;
    localparam int ISFD_MAG_W  = 16;
    localparam int ISFD_NUM_W  = 23;   // 2*mag*num + den, up to 8192008
    localparam int ISFD_TPROD_W = 32;

    // rounding: q = (2*mag*num + den) / (2*den)
    localparam int ISFD_ACCEL_NUM2 = 98;    // 2 * 49
    localparam int ISFD_ACCEL_DEN  = 40;
    localparam int ISFD_RATE_NUM2  = 250;   // 2 * 125
    localparam int ISFD_RATE_DEN   = 8;
    localparam int ISFD_ANGLE_NUM2 = 90;    // 2 * 45
    localparam int ISFD_ANGLE_DEN  = 32;

    // acceleration: /80 = shift by 4 then divide by 5 by reciprocal
    localparam int ISFD_ACCEL_SHIFT = 4;
    localparam int ISFD_DIV5_RECIP  = 209716;   // ceil(2^20 / 5)
    localparam int ISFD_DIV5_SHIFT  = 20;
    localparam int ISFD_RATE_SHIFT  = 4;        // /16
    localparam int ISFD_ANGLE_SHIFT = 6;        // /64

    // temperature: magnitude / 100 by reciprocal
    localparam int ISFD_DIV100_RECIP = 41944;   // ceil(2^22 / 100)
    localparam int ISFD_DIV100_SHIFT = 22;

    // result kinds
    typedef enum logic [1:0] {
        KIND_ACCEL = 2'd0,
        KIND_RATE  = 2'd1,
        KIND_ANGLE = 2'd2
    } kind_t;

    // complete, checked frame handed to the scaler
    typedef struct packed {
        kind_t                                kind;
        logic [ISFD_NUM_WORDS-1:0][15:0]      words;
    } frame_t;

    // intermediate products between the two scaler stages
    typedef struct packed {
        kind_t                                kind;
        logic [ISFD_NUM_AXES-1:0]             neg;
        logic [ISFD_NUM_AXES-1:0][ISFD_NUM_W-1:0] num;
        logic                                 tneg;
        logic [ISFD_TPROD_W-1:0]              tprod;
    } prod_t;

endpackage

@@ src/isfd_collector.sv @@
// ----------------------------------------------------------------------------
// isfd_collector
// Hunts for the header byte, collects an 11-byte frame by length, keeps the
// running 8-bit sum and hands a checked frame of known type to the scaler.
// ----------------------------------------------------------------------------
module isfd_collector (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           header_value,
    input  logic [7:0]           rx_byte,
    input  logic                 in_valid,
    output logic                 in_ready,
    output isfd_pkg::frame_t     frm,
    output logic                 frm_valid,
    input  logic                 frm_ready
);
    import isfd_pkg::*;

    logic [ISFD_POS_W-1:0] pos_reg, pos_next;
    logic [7:0]            sum_reg, sum_next;
    logic [7:0]            store_reg [ISFD_STORE_LO:ISFD_STORE_HI];
    logic                  frm_valid_reg;
    frame_t                frm_reg;
    logic                  in_fire;
    logic                  frm_load;
    logic                  kind_known;
    kind_t                 kind_dec;

    // a byte is taken whenever the frame register can hold a possible result
    assign in_ready = !frm_valid_reg || frm_ready;
    assign in_fire  = in_valid && in_ready;

    // type byte decode
    always_comb
    begin
        kind_known = 1'b1;
        kind_dec   = KIND_ACCEL;
        case (store_reg[ISFD_STORE_LO])
            ISFD_TYPE_ACCEL: kind_dec = KIND_ACCEL;
            ISFD_TYPE_RATE:  kind_dec = KIND_RATE;
            ISFD_TYPE_ANGLE: kind_dec = KIND_ANGLE;
            default:         kind_known = 1'b0;
        endcase
    end

    // framing: hunt, collect, check
    always_comb
    begin
        pos_next = pos_reg;
        sum_next = sum_reg;
        frm_load = 1'b0;
        if (in_fire)
        begin
            priority if (pos_reg == '0 || pos_reg > ISFD_POS_W'(ISFD_LAST_POS))
            begin
                pos_next = '0;
                if (rx_byte == header_value)
                begin
                    sum_next = rx_byte;
                    pos_next = ISFD_POS_W'(1);
                end
            end
            else if (pos_reg < ISFD_POS_W'(ISFD_LAST_POS))
            begin
                sum_next = sum_reg + rx_byte;
                pos_next = pos_reg + ISFD_POS_W'(1);
            end
            else
            begin
                pos_next = '0;
                sum_next = '0;
                frm_load = (rx_byte == sum_reg) && kind_known;
            end
        end
    end

    // position and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sum_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sum_reg <= sum_next;
        end
    end

    // frame bytes, each entry written at its own position
    always_ff @(posedge clk)
    begin
        for (int i = ISFD_STORE_LO; i <= ISFD_STORE_HI; i++)
        begin
            if (in_fire && pos_reg == ISFD_POS_W'(i))
                store_reg[i] <= rx_byte;
        end
    end

    // checked frame register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frm_valid_reg <= 1'b0;
        else if (frm_load)
            frm_valid_reg <= 1'b1;
        else if (frm_ready)
            frm_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (frm_load)
        begin
            frm_reg.kind <= kind_dec;
            for (int w = 0; w < ISFD_NUM_WORDS; w++)
                frm_reg.words[w] <= {store_reg[2*w + 3], store_reg[2*w + 2]};
        end
    end

    assign frm       = frm_reg;
    assign frm_valid = frm_valid_reg;

    // position stays inside the frame
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= ISFD_POS_W'(ISFD_LAST_POS))
        else $error("byte position left the frame");

    // a frame only comes out of a checksum byte
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frm_valid_reg) |-> $past(pos_reg) == ISFD_POS_W'(ISFD_LAST_POS))
        else $error("frame emitted away from the checksum byte");

    // after the checksum byte the block hunts again
    a_rehunt: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pos_reg == ISFD_POS_W'(ISFD_LAST_POS)) |=> pos_reg == '0)
        else $error("no return to hunting after checksum");

endmodule

@@ src/isfd_scaler.sv @@
// ----------------------------------------------------------------------------
// isfd_scaler
// Two pipeline stages turning a checked frame into Q.8 axis values with
// round-to-nearest and a truncated temperature, then the result register.
// ----------------------------------------------------------------------------
module isfd_scaler (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  isfd_pkg::frame_t                      frm,
    input  logic                                  frm_valid,
    output logic                                  frm_ready,
    output logic [1:0]                            frame_kind,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_x,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_y,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_z,
    output logic signed [isfd_pkg::ISFD_TEMP_W-1:0] temperature,
    output logic                                  out_valid,
    input  logic                                  out_ready
);
    import isfd_pkg::*;

    localparam int DIV5_PROD_W = (ISFD_NUM_W - ISFD_ACCEL_SHIFT) + 18;

    prod_t                    prod_next, prod_reg;
    logic                     s1_valid_reg;
    logic                     s1_ready;
    logic                     out_valid_reg;
    kind_t                    kind_reg;
    logic [ISFD_NUM_AXES-1:0][ISFD_AXIS_W-1:0] axis_next, axis_reg;
    logic [ISFD_TEMP_W-1:0]   temp_next, temp_reg;

    // stage handshakes
    assign s1_ready  = !out_valid_reg || out_ready;
    assign frm_ready = !s1_valid_reg || s1_ready;

    // stage 1: magnitudes and rounded numerators
    always_comb
    begin
        logic [ISFD_MAG_W-1:0] mag;
        logic [ISFD_MAG_W-1:0] tmag;
        mag  = '0;
        tmag = '0;
        prod_next.kind = frm.kind;
        for (int a = 0; a < ISFD_NUM_AXES; a++)
        begin
            prod_next.neg[a] = frm.words[a][15];
            mag = frm.words[a][15] ? (~frm.words[a] + 16'd1) : frm.words[a];
            unique case (frm.kind)
                KIND_ACCEL:
                    prod_next.num[a] = ISFD_NUM_W'(mag) * ISFD_NUM_W'(ISFD_ACCEL_NUM2)
                                       + ISFD_NUM_W'(ISFD_ACCEL_DEN);
                KIND_RATE:
                    prod_next.num[a] = ISFD_NUM_W'(mag) * ISFD_NUM_W'(ISFD_RATE_NUM2)
                                       + ISFD_NUM_W'(ISFD_RATE_DEN);
                KIND_ANGLE:
                    prod_next.num[a] = ISFD_NUM_W'(mag) * ISFD_NUM_W'(ISFD_ANGLE_NUM2)
                                       + ISFD_NUM_W'(ISFD_ANGLE_DEN);
                default:
                    prod_next.num[a] = '0;
            endcase
        end
        // temperature magnitude times reciprocal of 100
        prod_next.tneg  = frm.words[3][15];
        tmag            = frm.words[3][15] ? (~frm.words[3] + 16'd1) : frm.words[3];
        prod_next.tprod = ISFD_TPROD_W'(tmag) * ISFD_TPROD_W'(ISFD_DIV100_RECIP);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (frm_ready)
            s1_valid_reg <= frm_valid;
    end

    always_ff @(posedge clk)
    begin
        if (frm_ready && frm_valid)
            prod_reg <= prod_next;
    end

    // stage 2: divide by the rounding denominator, restore sign
    always_comb
    begin
        logic [DIV5_PROD_W-1:0]   dprod;
        logic [ISFD_AXIS_W-1:0]   q;
        logic [ISFD_TEMP_W-1:0]   tq;
        dprod = '0;
        q     = '0;
        for (int a = 0; a < ISFD_NUM_AXES; a++)
        begin
            dprod = '0;
            unique case (prod_reg.kind)
                KIND_ACCEL:
                begin
                    dprod = DIV5_PROD_W'(prod_reg.num[a][ISFD_NUM_W-1:ISFD_ACCEL_SHIFT])
                            * DIV5_PROD_W'(ISFD_DIV5_RECIP);
                    q = ISFD_AXIS_W'(dprod >> ISFD_DIV5_SHIFT);
                end
                KIND_RATE:
                    q = ISFD_AXIS_W'(prod_reg.num[a] >> ISFD_RATE_SHIFT);
                KIND_ANGLE:
                    q = ISFD_AXIS_W'(prod_reg.num[a] >> ISFD_ANGLE_SHIFT);
                default:
                    q = '0;
            endcase
            axis_next[a] = prod_reg.neg[a] ? (~q + ISFD_AXIS_W'(1)) : q;
        end
        tq = ISFD_TEMP_W'(prod_reg.tprod >> ISFD_DIV100_SHIFT);
        if (prod_reg.kind == KIND_ANGLE)
            temp_next = prod_reg.tneg ? (~tq + ISFD_TEMP_W'(1)) : tq;
        else
            temp_next = '0;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && s1_valid_reg)
        begin
            kind_reg <= prod_reg.kind;
            axis_reg <= axis_next;
            temp_reg <= temp_next;
        end
    end

    assign frame_kind  = kind_reg;
    assign axis_x      = axis_reg[0];
    assign axis_y      = axis_reg[1];
    assign axis_z      = axis_reg[2];
    assign temperature = temp_reg;
    assign out_valid   = out_valid_reg;

    // temperature is only carried by angle frames
    a_temp_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg != KIND_ANGLE) |-> temp_reg == '0)
        else $error("temperature set on a non-angle result");

endmodule

@@ src/imu_serial_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder
// Byte-stream decoder for 11-byte IMU frames with an APB header register.
// ----------------------------------------------------------------------------
// One received byte is taken per clock on the in_valid/in_ready channel, and
// in_ready stays high unless a finished result is stalled all the way back
// through the pipeline. Frames are delimited by length: a byte equal to
// header_value starts one, ten more bytes follow, and a header value inside a
// frame is plain data. A frame whose 8-bit checksum matches and whose type is
// 0x51, 0x52 or 0x53 yields one transaction on out_valid/out_ready, presented
// after it passes the frame register (loaded at the edge that takes its
// checksum byte), the product stage and the result register; anything else
// yields nothing. Axis values are signed Q.8 rounded to nearest with ties
// away from zero; temperature is the raw word divided by 100 toward zero for
// angle frames, and zero for the other kinds. header_value (address 0,
// reset 0x55) should be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [isfd_pkg::ISFD_ADDR_W-1:0]       paddr,
    input  logic [isfd_pkg::ISFD_DATA_W-1:0]       pwdata,
    output logic [isfd_pkg::ISFD_DATA_W-1:0]       prdata,
    output logic                                   pready,
    // received bytes
    input  logic [7:0]                             rx_byte,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    // decoded results
    output logic [1:0]                             frame_kind,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_x,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_y,
    output logic signed [isfd_pkg::ISFD_AXIS_W-1:0] axis_z,
    output logic signed [isfd_pkg::ISFD_TEMP_W-1:0] temperature,
    output logic                                   out_valid,
    input  logic                                   out_ready
);
    import isfd_pkg::*;

    logic [7:0] header_reg;
    logic       cfg_write;
    frame_t     frm;
    logic       frm_valid;
    logic       frm_ready;

    // header register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= ISFD_HEADER_RESET;
        else if (cfg_write && paddr[2] == ISFD_REG_HEADER)
            header_reg <= pwdata[7:0];
    end

    // read back
    always_comb
    begin
        if (paddr[2] == ISFD_REG_HEADER)
            prdata = ISFD_DATA_W'(header_reg);
        else
            prdata = '0;
    end

    // framing
    isfd_collector u_collector (
        .clk          (clk),
        .rst_n        (rst_n),
        .header_value (header_reg),
        .rx_byte      (rx_byte),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frm          (frm),
        .frm_valid    (frm_valid),
        .frm_ready    (frm_ready)
    );

    // scaling and result register
    isfd_scaler u_scaler (
        .clk         (clk),
        .rst_n       (rst_n),
        .frm         (frm),
        .frm_valid   (frm_valid),
        .frm_ready   (frm_ready),
        .frame_kind  (frame_kind),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .temperature (temperature),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

endmodule

@@ dv/imu_serial_frame_decoder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// imu_serial_frame_decoder_tb
// Self-checking bench for the IMU serial frame decoder. A byte driver feeds
// directed and random frames: good ones, bad checksums, unknown types and
// noise. Each accepted byte goes through a local frame predictor, and the
// results it expects are queued. A checker compares every output transaction
// field by field with the oldest queued result. The header register is
// changed between phases while the block is idle, and both sides idle and
// stall at random.
// ----------------------------------------------------------------------------
module imu_serial_frame_decoder_tb;

    import isfd_pkg::*;

    localparam int FRAME_BYTES    = 11;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [ISFD_ADDR_W-1:0] HEADER_ADDR = {ISFD_REG_HEADER, 2'b00};
    localparam logic [ISFD_ADDR_W-1:0] SPARE_ADDR  = {~ISFD_REG_HEADER, 2'b00};

    // one decoded frame as seen on the output
    typedef struct {
        kind_t                         kind;
        logic signed [ISFD_AXIS_W-1:0] ax;
        logic signed [ISFD_AXIS_W-1:0] ay;
        logic signed [ISFD_AXIS_W-1:0] az;
        logic signed [ISFD_TEMP_W-1:0] temp;
    } imu_result_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          psel      = 1'b0;
    logic                          penable   = 1'b0;
    logic                          pwrite    = 1'b0;
    logic [ISFD_ADDR_W-1:0]        paddr     = '0;
    logic [ISFD_DATA_W-1:0]        pwdata    = '0;
    logic [ISFD_DATA_W-1:0]        prdata;
    logic                          pready;
    logic [7:0]                    rx_byte   = 8'h00;
    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic [1:0]                    frame_kind;
    logic signed [ISFD_AXIS_W-1:0] axis_x;
    logic signed [ISFD_AXIS_W-1:0] axis_y;
    logic signed [ISFD_AXIS_W-1:0] axis_z;
    logic signed [ISFD_TEMP_W-1:0] temperature;
    logic                          out_valid;
    logic                          out_ready = 1'b0;

    // frame predictor state
    logic [7:0]  header_reg = ISFD_HEADER_RESET;
    logic [7:0]  frame_bytes [FRAME_BYTES];
    logic [3:0]  frame_pos  = '0;
    logic [7:0]  frame_sum  = '0;

    imu_result_t decoded_frames [$];

    int err_count      = 0;
    int sent_items     = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;

    imu_serial_frame_decoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .rx_byte     (rx_byte),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .frame_kind  (frame_kind),
        .axis_x      (axis_x),
        .axis_y      (axis_y),
        .axis_z      (axis_z),
        .temperature (temperature),
        .out_valid   (out_valid),
        .out_ready   (out_ready)
    );

    // clock
    always #5 clk = ~clk;

    // error reporting
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_count++;
    endtask

    // round(w * num / den), ties away from zero
    function automatic logic signed [ISFD_AXIS_W-1:0] scale_axis(input int w, input int num,
                                                                 input int den);
        int mag;
        int q;
        mag = (w < 0) ? -w : w;
        q   = (2 * mag * num + den) / (2 * den);
        return ISFD_AXIS_W'((w < 0) ? -q : q);
    endfunction

    function automatic int frame_word(input int lo);
        logic signed [15:0] s;
        s = {frame_bytes[lo+1], frame_bytes[lo]};
        return int'(s);
    endfunction

    // decode a frame whose checksum matched
    task automatic decode_frame();
        imu_result_t r;
        int          num;
        int          den;
        bit          known;
        known = 1'b1;
        num   = 0;
        den   = 1;
        r.kind = KIND_ACCEL;
        case (frame_bytes[1])
            ISFD_TYPE_ACCEL: begin r.kind = KIND_ACCEL; num = 49;  den = 40; end
            ISFD_TYPE_RATE:  begin r.kind = KIND_RATE;  num = 125; den = 8;  end
            ISFD_TYPE_ANGLE: begin r.kind = KIND_ANGLE; num = 45;  den = 32; end
            default:         known = 1'b0;
        endcase
        if (known)
        begin
            r.ax   = scale_axis(frame_word(2), num, den);
            r.ay   = scale_axis(frame_word(4), num, den);
            r.az   = scale_axis(frame_word(6), num, den);
            r.temp = (r.kind == KIND_ANGLE) ? ISFD_TEMP_W'(frame_word(8) / 100) : '0;
            decoded_frames.push_back(r);
        end
    endtask

    // frame assembly on each accepted byte
    task automatic predict_byte(input logic [7:0] b);
        if (frame_pos == 0 || frame_pos >= FRAME_BYTES)
        begin
            frame_pos = '0;
            if (b == header_reg)
            begin
                frame_bytes[0] = b;
                frame_sum      = b;
                frame_pos      = 4'd1;
            end
        end
        else if (frame_pos < ISFD_LAST_POS)
        begin
            frame_bytes[frame_pos] = b;
            frame_sum = frame_sum + b;
            frame_pos = frame_pos + 4'd1;
        end
        else
        begin
            frame_bytes[ISFD_LAST_POS] = b;
            frame_pos = '0;
            if (b == frame_sum)
                decode_frame();
            frame_sum = '0;
        end
    endtask

    // one input transaction, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_byte(b);
        sent_items++;
    endtask

    // full frame with the current header
    task automatic send_frame(input logic [7:0] type_code, input logic [15:0] w0,
                              input logic [15:0] w1, input logic [15:0] w2,
                              input logic [15:0] w3, input bit bad_sum);
        logic [7:0] bytes [FRAME_BYTES];
        logic [7:0] sum;
        bytes[0] = header_reg;
        bytes[1] = type_code;
        {bytes[3], bytes[2]} = w0;
        {bytes[5], bytes[4]} = w1;
        {bytes[7], bytes[6]} = w2;
        {bytes[9], bytes[8]} = w3;
        sum = '0;
        for (int i = 0; i < ISFD_LAST_POS; i++)
            sum = sum + bytes[i];
        bytes[ISFD_LAST_POS] = bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum;
        for (int i = 0; i < FRAME_BYTES; i++)
            send_byte(bytes[i]);
    endtask

    // sender holds off until every pending result is out
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (decoded_frames.size() != 0) @(posedge clk);
    endtask

    // close any partial frame and let the pipeline empty
    task automatic quiesce();
        while (frame_pos != 0) send_byte(8'h00);
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // register write, setup then access, then back to idle
    task automatic apb_write(input logic [ISFD_ADDR_W-1:0] addr,
                             input logic [ISFD_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == HEADER_ADDR)
            header_reg = data[7:0];
        @(posedge clk);
    endtask

    // register read and compare, then back to idle
    task automatic apb_check(input logic [ISFD_ADDR_W-1:0] addr,
                             input logic [ISFD_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
            report_error($sformatf("register read at %0d: got %h expected %h",
                                   addr, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // word picker biased toward extremes and rounding ties
    function automatic logic [15:0] random_word();
        logic [15:0] picks [14] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001,
                                    -16'sd100, -16'sd99, 16'd100, 16'd20, -16'sd20,
                                    16'd4, -16'sd4, 16'd16, -16'sd16};
        case ($urandom_range(0, 7))
            0:       return picks[$urandom_range(0, 13)];
            1:       return 16'($signed($urandom_range(0, 128)) - 64);
            default: return 16'($urandom);
        endcase
    endfunction

    // reset value, masking and the unused register slot
    task automatic test_register_access();
        apb_check(HEADER_ADDR, {24'h0, ISFD_HEADER_RESET});
        apb_write(SPARE_ADDR, $urandom);
        apb_check(HEADER_ADDR, {24'h0, ISFD_HEADER_RESET});
        apb_write(HEADER_ADDR, {24'hA5C3E1, 8'h3C});
        apb_check(HEADER_ADDR, 32'h3C);
        apb_write(HEADER_ADDR, {24'h0, ISFD_HEADER_RESET});
        apb_check(HEADER_ADDR, {24'h0, ISFD_HEADER_RESET});
    endtask

    // stray byte, then one frame of each kind at the extremes
    task automatic test_directed_frames();
        send_byte(~header_reg);
        send_frame(ISFD_TYPE_ACCEL, 16'h7fff, 16'h8000, 16'd20, 16'h8000, 1'b0);
        // header value inside the payload is plain data
        send_frame(ISFD_TYPE_RATE, 16'd4, -16'sd4, 16'h8000, {8'h12, header_reg}, 1'b0);
        send_frame(ISFD_TYPE_ANGLE, 16'd16, -16'sd16, 16'h7fff, 16'h8000, 1'b0);
        quiesce();
    endtask

    // random frames, broken frames and noise under one header and idle mix
    task automatic test_random_traffic(input int item_count, input int s_pct,
                                       input int r_pct, input logic [7:0] hdr);
        int         target;
        int         sel;
        logic [7:0] code;
        quiesce();
        apb_write(HEADER_ADDR, {24'($urandom), hdr});
        apb_check(HEADER_ADDR, {24'h0, hdr});
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        target = sent_items + item_count;
        while (sent_items < target)
        begin
            sel = $urandom_range(0, 99);
            case ($urandom_range(0, 2))
                0:       code = ISFD_TYPE_ACCEL;
                1:       code = ISFD_TYPE_RATE;
                default: code = ISFD_TYPE_ANGLE;
            endcase
            if (sel < 70)
                send_frame(code, random_word(), random_word(), random_word(),
                           random_word(), 1'b0);
            else if (sel < 80)
                send_frame(code, random_word(), random_word(), random_word(),
                           random_word(), 1'b1);
            else if (sel < 87)
            begin
                code = 8'($urandom);
                if (code[7:2] == ISFD_TYPE_ACCEL[7:2])
                    code[7] = ~code[7];
                send_frame(code, random_word(), random_word(), random_word(),
                           random_word(), 1'b0);
            end
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            if ($urandom_range(0, 29) == 0)
                pause_until_drained();
        end
        quiesce();
    endtask

    // receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);

    // result checker
    always @(posedge clk)
    begin : check_result
        imu_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (decoded_frames.size() == 0)
                report_error("output transaction with no decoded frame pending");
            else
            begin
                want = decoded_frames.pop_front();
                if (frame_kind !== want.kind)
                    report_error($sformatf("frame_kind: got %0d expected %0d",
                                           frame_kind, want.kind));
                if (axis_x !== want.ax)
                    report_error($sformatf("axis_x: got %0d expected %0d", axis_x, want.ax));
                if (axis_y !== want.ay)
                    report_error($sformatf("axis_y: got %0d expected %0d", axis_y, want.ay));
                if (axis_z !== want.az)
                    report_error($sformatf("axis_z: got %0d expected %0d", axis_z, want.az));
                if (temperature !== want.temp)
                    report_error($sformatf("temperature: got %0d expected %0d",
                                           temperature, want.temp));
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // test sequence
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_directed_frames();
        test_random_traffic(250, 0, 0, ISFD_HEADER_RESET);
        test_random_traffic(250, 50, 0, 8'h00);
        test_random_traffic(250, 0, 50, 8'hFF);
        test_random_traffic(250, 35, 35, 8'($urandom));
        test_random_traffic(250, 35, 35, ISFD_HEADER_RESET);
        quiesce();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
src/isfd_pkg.sv
src/isfd_collector.sv
src/isfd_scaler.sv
src/imu_serial_frame_decoder.sv
dv/imu_serial_frame_decoder_tb.sv
